[rtl/abkf_pkg.sv]
// ----------------------------------------------------------------------------
// abkf_pkg: shared types and constants for the angle / bias Kalman filter
// Holds the register map, operation codes, the ALU command set and helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package abkf_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW = 5;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpInit   = 1'b1;

  localparam logic [2:0] RegQAngle  = 3'd0;
  localparam logic [2:0] RegQUpper  = 3'd1;
  localparam logic [2:0] RegQLower  = 3'd2;
  localparam logic [2:0] RegQBias   = 3'd3;
  localparam logic [2:0] RegMeasN   = 3'd4;
  localparam logic [2:0] RegStAngle = 3'd5;
  localparam logic [2:0] RegStBias  = 3'd6;
  localparam logic [2:0] RegStVar   = 3'd7;

  // Commands of the shared arithmetic unit.
  typedef enum logic [2:0] {
    AluAdd,
    AluSub,
    AluScale,
    AluMul,
    AluDiv
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic signed [DataW-1:0] res;
  } alu_rsp_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [95:0] v);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    hi = 96'sh7FFF_FFFF;
    lo = -96'sh8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/abkf_if.sv]
// ----------------------------------------------------------------------------
// abkf_in_if / abkf_out_if: valid/ready channels of the filter
// Input words carry one item, output words carry one result.
// ----------------------------------------------------------------------------
`default_nettype none
interface abkf_in_if;
  logic valid;
  logic ready;
  logic op;
  logic signed [31:0] rate;
  logic signed [31:0] measured_angle;
  logic [15:0] elapsed_ms;
  modport source (output valid, op, rate, measured_angle, elapsed_ms, input ready);
  modport sink (input valid, op, rate, measured_angle, elapsed_ms, output ready);
endinterface

interface abkf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] angle_out;
  logic valid_res;
  modport source (output valid, angle_out, valid_res, input ready);
  modport sink (input valid, angle_out, valid_res, output ready);
endinterface
`default_nettype wire

[rtl/abkf_alu.sv]
// ----------------------------------------------------------------------------
// abkf_alu: shared saturating arithmetic unit
// Add, subtract, scale and multiply run through the SMul and SFin states; divide runs bit-serially.
// ----------------------------------------------------------------------------
`default_nettype none
module abkf_alu #(
  parameter int unsigned FRAC_BITS = abkf_pkg::FracBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire abkf_pkg::alu_req_t req,
  output abkf_pkg::alu_rsp_t rsp
);
  localparam int unsigned QW = 32 + FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(QW + 1);

  typedef enum logic [1:0] {SIdle, SMul, SDiv, SFin} st_t;
  st_t st;
  abkf_pkg::alu_op_t op;
  logic signed [31:0] a, b;
  logic signed [63:0] prod;
  logic [QW-1:0] dividend;
  logic [QW-1:0] quot;
  logic [32:0] rem;
  logic [32:0] dmag;
  logic neg;
  logic [CW-1:0] cnt;
  logic signed [95:0] wide;

  logic [33:0] trial;
  logic [32:0] rem_sh;

  always_comb begin
    rem_sh = {rem[31:0], dividend[QW-1]};
    trial = {1'b0, rem_sh} - {1'b0, dmag};
  end

  always_comb begin
    logic signed [QW:0] sq;
    sq = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    case (op)
      abkf_pkg::AluAdd: wide = 96'(a) + 96'(b);
      abkf_pkg::AluSub: wide = 96'(a) - 96'(b);
      abkf_pkg::AluScale: wide = 96'(prod);
      abkf_pkg::AluMul: wide = 96'(prod) >>> FRAC_BITS;
      abkf_pkg::AluDiv: wide = 96'(sq);
      default: wide = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SIdle;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (st)
        SIdle: begin
          if (req.start) begin
            op <= req.op;
            a <= req.a;
            b <= req.b;
            if (req.op == abkf_pkg::AluDiv) begin
              neg <= req.a[31] ^ req.b[31];
              dividend <= QW'(req.a[31] ? -33'(req.a) : 33'(req.a)) << FRAC_BITS;
              dmag <= req.b[31] ? -33'(req.b) : 33'(req.b);
              rem <= '0;
              quot <= '0;
              cnt <= CW'(QW);
              st <= (req.b == 0) ? SFin : SDiv;
            end else begin
              st <= SMul;
            end
          end
        end
        SMul: begin
          if (op == abkf_pkg::AluScale) prod <= $signed({32'd0, a[15:0]}) * 64'(b);
          else prod <= 64'(a) * 64'(b);
          st <= SFin;
        end
        SDiv: begin
          dividend <= dividend << 1;
          if (!trial[33]) begin
            rem <= trial[32:0];
            quot <= {quot[QW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quot <= {quot[QW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) st <= SFin;
        end
        SFin: begin
          rsp.done <= 1'b1;
          rsp.res <= (op == abkf_pkg::AluDiv && b == 0) ? '0 : abkf_pkg::sat32(wide);
          st <= SIdle;
        end
        default: st <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/angle_bias_kalman_filter_top.sv]
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_top: two-state angle / gyro-bias Kalman filter
// A sequencer walks a fixed program of saturating operations on one ALU.
// ----------------------------------------------------------------------------
//
//  Channel  Role      Word
//  in       sink      op, rate, measured_angle, elapsed_ms
//  out      source    angle_out, valid_res
//  apb      slave     eight 32-bit registers at byte address 4*i
//
// An update word runs 33 ALU operations: 25 for the prediction, gains and
// states and 8 for the covariance correction. An add, subtract, scale or
// multiply passes from SIssue through the ALU states SMul and SFin to
// write-back in SWait. Each of the two divisions runs bit-serially: the
// divider retires one quotient bit per cycle over 49 bits at the default
// FRAC_BITS, or skips to SFin for a zero divisor. An update offers its
// result once both programs are done. An initialize or an update before
// initialize offers its result in the cycle after acceptance. rst is
// synchronous and clears the state and the registers to their defaults. The
// result is held in an output register; a new word is not taken until the
// previous result has been accepted.
`default_nettype none
module angle_bias_kalman_filter_top #(
  parameter int unsigned FRAC_BITS = abkf_pkg::FracBitsDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  abkf_in_if.sink   in_ch,
  abkf_out_if.source out_ch,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [abkf_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  // Configuration registers.
  logic signed [31:0] cfg [abkf_pkg::NumRegs];
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;
  assign prdata = cfg[ridx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[0] <= 32'sd66;
      cfg[1] <= '0;
      cfg[2] <= '0;
      cfg[3] <= 32'sd197;
      cfg[4] <= 32'sd1966;
      cfg[5] <= '0;
      cfg[6] <= '0;
      cfg[7] <= '0;
    end else if (psel && penable && pwrite) begin
      if (ridx == abkf_pkg::RegMeasN || ridx == abkf_pkg::RegStVar)
        cfg[ridx] <= {1'b0, pwdata[30:0]};
      else
        cfg[ridx] <= pwdata;
    end
  end

  // Scratch register file: filter state and temporaries.
  // 0 angle 1 bias 2 p00 3 p01 4 p10 5 p11 6 rate 7 meas 8 dt
  // 9 xb0 10 t 11 b00 12 b01 13 b10 14 b11 15 den 16 k0 17 k1 18 innov
  // 19..26 configuration copies.
  localparam int unsigned NR = 27;
  logic signed [31:0] r [NR];
  logic initd;

  typedef struct packed {
    abkf_pkg::alu_op_t op;
    logic [4:0] sa;
    logic [4:0] sb;
    logic [4:0] d;
  } instr_t;

  localparam int unsigned NI = 25;
  function automatic instr_t prog(input logic [4:0] pc);
    instr_t i;
    case (pc)
      5'd0:  i = '{abkf_pkg::AluSub,   5'd6,  5'd1,  5'd10};
      5'd1:  i = '{abkf_pkg::AluScale, 5'd8,  5'd10, 5'd10};
      5'd2:  i = '{abkf_pkg::AluAdd,   5'd0,  5'd10, 5'd9};
      5'd3:  i = '{abkf_pkg::AluScale, 5'd8,  5'd5,  5'd10};
      5'd4:  i = '{abkf_pkg::AluSub,   5'd10, 5'd4,  5'd10};
      5'd5:  i = '{abkf_pkg::AluSub,   5'd10, 5'd3,  5'd10};
      5'd6:  i = '{abkf_pkg::AluAdd,   5'd10, 5'd19, 5'd10};
      5'd7:  i = '{abkf_pkg::AluScale, 5'd8,  5'd10, 5'd10};
      5'd8:  i = '{abkf_pkg::AluAdd,   5'd2,  5'd10, 5'd11};
      5'd9:  i = '{abkf_pkg::AluSub,   5'd20, 5'd5,  5'd10};
      5'd10: i = '{abkf_pkg::AluScale, 5'd8,  5'd10, 5'd10};
      5'd11: i = '{abkf_pkg::AluAdd,   5'd3,  5'd10, 5'd12};
      5'd12: i = '{abkf_pkg::AluSub,   5'd21, 5'd5,  5'd10};
      5'd13: i = '{abkf_pkg::AluScale, 5'd8,  5'd10, 5'd10};
      5'd14: i = '{abkf_pkg::AluAdd,   5'd4,  5'd10, 5'd13};
      5'd15: i = '{abkf_pkg::AluScale, 5'd8,  5'd22, 5'd10};
      5'd16: i = '{abkf_pkg::AluAdd,   5'd5,  5'd10, 5'd14};
      5'd17: i = '{abkf_pkg::AluAdd,   5'd11, 5'd23, 5'd15};
      5'd18: i = '{abkf_pkg::AluDiv,   5'd11, 5'd15, 5'd16};
      5'd19: i = '{abkf_pkg::AluDiv,   5'd13, 5'd15, 5'd17};
      5'd20: i = '{abkf_pkg::AluSub,   5'd7,  5'd9,  5'd18};
      5'd21: i = '{abkf_pkg::AluMul,   5'd16, 5'd18, 5'd10};
      5'd22: i = '{abkf_pkg::AluAdd,   5'd9,  5'd10, 5'd0};
      5'd23: i = '{abkf_pkg::AluMul,   5'd17, 5'd18, 5'd10};
      5'd24: i = '{abkf_pkg::AluAdd,   5'd1,  5'd10, 5'd1};
      default: i = '{abkf_pkg::AluAdd, 5'd0,  5'd0,  5'd0};
    endcase
    return i;
  endfunction

  // Covariance correction: p = b - k*b, run as a second short program.
  function automatic instr_t prog2(input logic [4:0] pc);
    instr_t i;
    case (pc)
      5'd0: i = '{abkf_pkg::AluMul, 5'd16, 5'd11, 5'd10};
      5'd1: i = '{abkf_pkg::AluSub, 5'd11, 5'd10, 5'd2};
      5'd2: i = '{abkf_pkg::AluMul, 5'd16, 5'd12, 5'd10};
      5'd3: i = '{abkf_pkg::AluSub, 5'd12, 5'd10, 5'd3};
      5'd4: i = '{abkf_pkg::AluMul, 5'd17, 5'd11, 5'd10};
      5'd5: i = '{abkf_pkg::AluSub, 5'd13, 5'd10, 5'd4};
      5'd6: i = '{abkf_pkg::AluMul, 5'd17, 5'd12, 5'd10};
      5'd7: i = '{abkf_pkg::AluSub, 5'd14, 5'd10, 5'd5};
      default: i = '{abkf_pkg::AluAdd, 5'd0, 5'd0, 5'd0};
    endcase
    return i;
  endfunction

  typedef enum logic [2:0] {SIdle, SIssue, SWait, SOut} st_t;
  st_t st;
  logic [4:0] pc;
  logic phase2;
  instr_t cur;
  abkf_pkg::alu_req_t req;
  abkf_pkg::alu_rsp_t rsp;

  assign cur = phase2 ? prog2(pc) : prog(pc);

  always_comb begin
    req.start = (st == SIssue);
    req.op = cur.op;
    req.a = r[cur.sa];
    req.b = r[cur.sb];
  end

  abkf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign in_ch.ready = (st == SIdle);
  assign out_ch.valid = (st == SOut);
  assign out_ch.angle_out = initd ? r[0] : '0;
  assign out_ch.valid_res = initd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= SIdle;
      initd <= 1'b0;
      pc <= '0;
      phase2 <= 1'b0;
      for (int k = 0; k < NR; k++) r[k] <= '0;
    end else begin
      unique case (st)
        SIdle: begin
          if (in_ch.valid) begin
            if (in_ch.op == abkf_pkg::OpInit) begin
              r[0] <= cfg[abkf_pkg::RegStAngle];
              r[1] <= cfg[abkf_pkg::RegStBias];
              r[2] <= cfg[abkf_pkg::RegStVar];
              r[3] <= '0;
              r[4] <= '0;
              r[5] <= cfg[abkf_pkg::RegStVar];
              initd <= 1'b1;
              st <= SOut;
            end else if (initd) begin
              r[6] <= in_ch.rate;
              r[7] <= in_ch.measured_angle;
              r[8] <= {16'd0, in_ch.elapsed_ms};
              for (int k = 0; k < 8; k++) r[19 + k] <= cfg[k];
              pc <= '0;
              phase2 <= 1'b0;
              st <= SIssue;
            end else begin
              st <= SOut;
            end
          end
        end
        SIssue: st <= SWait;
        SWait: begin
          if (rsp.done) begin
            r[cur.d] <= rsp.res;
            if (!phase2 && pc == 5'(NI - 1)) begin
              phase2 <= 1'b1;
              pc <= '0;
              st <= SIssue;
            end else if (phase2 && pc == 5'd7) begin
              st <= SOut;
            end else begin
              pc <= pc + 1'b1;
              st <= SIssue;
            end
          end
        end
        SOut: if (out_ch.ready) st <= SIdle;
        default: st <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
